@@ rtl/sspb_pkg.sv @@
// shared types and constants for the swept-sphere polyline bounds block
// no dependencies; imported by the lane, merge and top level modules
package sspb_pkg;

   // fixed field widths of the point and box transfers
   localparam int IN_WIDTH            = 32;
   localparam int RADIUS_WIDTH        = 31;
   localparam int OUT_WIDTH           = 32;
   // width that holds point +/- radius without overflow
   localparam int SUM_WIDTH           = 34;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int AXES                = 3;

   // per-stage control that travels alongside the lane data
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } sspb_ctl_type;

endpackage

@@ rtl/sspb_lane.sv @@
// one coordinate axis: segment endpoint min/max, radius widening and clamp
// depends on sspb_pkg; two register stages, advanced by a shared enable
module sspb_lane #(
   parameter int COORD_WIDTH = sspb_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    advance,
   input  logic                                    accept,
   input  logic                                    first,
   input  logic signed [sspb_pkg::IN_WIDTH-1:0]    point,
   input  logic        [sspb_pkg::RADIUS_WIDTH-1:0] rad,
   output logic signed [COORD_WIDTH-1:0]           lower,
   output logic signed [COORD_WIDTH-1:0]           upper,
   output logic                                    clamped
);
   import sspb_pkg::*;

   localparam int EW = (COORD_WIDTH + 1 > SUM_WIDTH) ? COORD_WIDTH + 1 : SUM_WIDTH;
   localparam logic signed [EW-1:0] HI_LIM = EW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] LO_LIM = -HI_LIM - EW'(1);

   logic signed [IN_WIDTH-1:0]     prev_ff;
   logic signed [IN_WIDTH-1:0]     lo_pt_in, lo_pt_ff, hi_pt_in, hi_pt_ff;
   logic        [RADIUS_WIDTH-1:0] rad_ff;
   logic signed [EW-1:0]           lo_sum, hi_sum;
   logic signed [EW-1:0]           lo_clip, hi_clip;
   logic                           lo_flag, hi_flag;
   logic signed [COORD_WIDTH-1:0]  lower_ff, upper_ff;
   logic                           clamped_ff;

   // previous point of the fiber
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff <= point;
      end
   end

   // segment endpoints, or the point alone when it opens a fiber
   always_comb begin
      if (first) begin
         lo_pt_in = point;
         hi_pt_in = point;
      end else begin
         lo_pt_in = (point < prev_ff) ? point : prev_ff;
         hi_pt_in = (point > prev_ff) ? point : prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_pt_ff <= lo_pt_in;
         hi_pt_ff <= hi_pt_in;
         rad_ff   <= rad;
      end
   end

   // exact widened bounds
   assign lo_sum = EW'(lo_pt_ff) - $signed(EW'(rad_ff));
   assign hi_sum = EW'(hi_pt_ff) + $signed(EW'(rad_ff));

   // clamp both bounds to the coordinate range on either side
   always_comb begin
      lo_flag = 1'b1;
      hi_flag = 1'b1;
      if (lo_sum > HI_LIM) begin
         lo_clip = HI_LIM;
      end else if (lo_sum < LO_LIM) begin
         lo_clip = LO_LIM;
      end else begin
         lo_clip = lo_sum;
         lo_flag = 1'b0;
      end
      if (hi_sum > HI_LIM) begin
         hi_clip = HI_LIM;
      end else if (hi_sum < LO_LIM) begin
         hi_clip = LO_LIM;
      end else begin
         hi_clip = hi_sum;
         hi_flag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lower_ff   <= lo_clip[COORD_WIDTH-1:0];
         upper_ff   <= hi_clip[COORD_WIDTH-1:0];
         clamped_ff <= lo_flag | hi_flag;
      end
   end

   assign lower   = lower_ff;
   assign upper   = upper_ff;
   assign clamped = clamped_ff;

endmodule

@@ rtl/sspb_merge.sv @@
// merges the three lane results into the running box and holds the result
// depends on sspb_pkg; owns the box, the clamp flag and the rsp register
module sspb_merge #(
   parameter int COORD_WIDTH = sspb_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  sspb_pkg::sspb_ctl_type                 ctl,
   input  logic signed [COORD_WIDTH-1:0]          lower   [sspb_pkg::AXES],
   input  logic signed [COORD_WIDTH-1:0]          upper   [sspb_pkg::AXES],
   input  logic        [sspb_pkg::AXES-1:0]       clamped,
   output logic                                   rsp_valid,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_min_x,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_min_y,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_min_z,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_max_x,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_max_y,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]  rsp_max_z,
   output logic                                   rsp_saturated
);
   import sspb_pkg::*;

   logic signed [COORD_WIDTH-1:0] box_lo_ff [AXES];
   logic signed [COORD_WIDTH-1:0] box_hi_ff [AXES];
   logic signed [COORD_WIDTH-1:0] box_lo_in [AXES];
   logic signed [COORD_WIDTH-1:0] box_hi_in [AXES];
   logic                          clamp_ff, clamp_in;
   logic signed [OUT_WIDTH-1:0]   out_lo_ff [AXES];
   logic signed [OUT_WIDTH-1:0]   out_hi_ff [AXES];
   logic                          sat_ff, valid_ff;
   logic                          take;

   assign take = advance & ctl.valid;

   // union of the segment box into the running box
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (ctl.first) begin
            box_lo_in[i] = lower[i];
            box_hi_in[i] = upper[i];
         end else begin
            box_lo_in[i] = (lower[i] < box_lo_ff[i]) ? lower[i] : box_lo_ff[i];
            box_hi_in[i] = (upper[i] > box_hi_ff[i]) ? upper[i] : box_hi_ff[i];
         end
      end
      clamp_in = clamp_ff | (|clamped);
   end

   // running box
   always_ff @(posedge clock) begin
      if (take) begin
         box_lo_ff <= box_lo_in;
         box_hi_ff <= box_hi_in;
      end
   end

   // sticky clamp flag, cleared once the fiber is sent
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b0;
      end else if (take) begin
         clamp_ff <= ctl.last ? 1'b0 : clamp_in;
      end
   end

   // output register, loaded on the last point of a fiber
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl.valid & ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (take && ctl.last) begin
         for (int i = 0; i < AXES; i++) begin
            out_lo_ff[i] <= OUT_WIDTH'(box_lo_in[i]);
            out_hi_ff[i] <= OUT_WIDTH'(box_hi_in[i]);
         end
         sat_ff <= clamp_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_min_x     = out_lo_ff[0];
   assign rsp_min_y     = out_lo_ff[1];
   assign rsp_min_z     = out_lo_ff[2];
   assign rsp_max_x     = out_hi_ff[0];
   assign rsp_max_y     = out_hi_ff[1];
   assign rsp_max_z     = out_hi_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

@@ rtl/swept_sphere_polyline_bounds.sv @@
// top level of the swept-sphere polyline bounds block
// depends on sspb_pkg, sspb_lane and sspb_merge
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | x, y, z, radius, last
//   rsp     | out       | rsp_valid / rsp_stall | min/max x y z, saturated
//
// one point per cycle sustained while rsp is not stalled; the last point of a fiber passes the lane
// stage registers, then the merge output register, before its box is on rsp
// the running box compare in the merge stage is a feedback loop, a min and a max compare per axis
// reset is synchronous and clears control state; the first point after reset opens a fiber
// a stalled rsp holds the whole pipeline, so req_stall follows rsp_valid && rsp_stall
module swept_sphere_polyline_bounds #(
   parameter int COORD_WIDTH = sspb_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sspb_pkg::IN_WIDTH-1:0]    req_x,
   input  logic signed [sspb_pkg::IN_WIDTH-1:0]    req_y,
   input  logic signed [sspb_pkg::IN_WIDTH-1:0]    req_z,
   input  logic        [sspb_pkg::RADIUS_WIDTH-1:0] req_radius,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_min_x,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_min_y,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_min_z,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_max_x,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_max_y,
   output logic signed [sspb_pkg::OUT_WIDTH-1:0]   rsp_max_z,
   output logic                                    rsp_saturated
);
   import sspb_pkg::*;

   logic                          advance, accept;
   logic                          first_ff;
   logic [RADIUS_WIDTH-1:0]       prev_rad_ff, rad_sel;
   sspb_ctl_type                  s1_ctl_ff, s2_ctl_ff;
   logic signed [IN_WIDTH-1:0]    point [AXES];
   logic signed [COORD_WIDTH-1:0] lane_lo [AXES];
   logic signed [COORD_WIDTH-1:0] lane_hi [AXES];
   logic [AXES-1:0]               lane_clamp;

   // pipeline moves unless the result register is full and stalled
   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;
   assign accept    = req_valid & advance;

   // fiber start tracking and previous radius
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (accept) begin
         first_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_rad_ff <= req_radius;
      end
   end

   // widening radius: own radius on a first point, else the larger of the two
   assign rad_sel = (first_ff || req_radius > prev_rad_ff) ? req_radius : prev_rad_ff;

   // control that follows the lane stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= '{valid: accept, first: first_ff, last: req_last};
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   assign point[0] = req_x;
   assign point[1] = req_y;
   assign point[2] = req_z;

   // one lane per axis
   for (genvar g = 0; g < AXES; g++) begin : g_lane
      sspb_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .clock   (clock),
         .advance (advance),
         .accept  (accept),
         .first   (first_ff),
         .point   (point[g]),
         .rad     (rad_sel),
         .lower   (lane_lo[g]),
         .upper   (lane_hi[g]),
         .clamped (lane_clamp[g])
      );
   end

   sspb_merge #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctl           (s2_ctl_ff),
      .lower         (lane_lo),
      .upper         (lane_hi),
      .clamped       (lane_clamp),
      .rsp_valid     (rsp_valid),
      .rsp_min_x     (rsp_min_x),
      .rsp_min_y     (rsp_min_y),
      .rsp_min_z     (rsp_min_z),
      .rsp_max_x     (rsp_max_x),
      .rsp_max_y     (rsp_max_y),
      .rsp_max_z     (rsp_max_z),
      .rsp_saturated (rsp_saturated)
   );

   // a result only follows the last point of a fiber in the merge stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s2_ctl_ff.valid && s2_ctl_ff.last))
      else $error("result raised without a last point");

   // accepting a point that is not last closes the fiber opening
   a_first_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_last) |=> !first_ff)
      else $error("fiber start flag not cleared");

   // a point stage that is not first must not follow a last point
   a_first_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_ctl_ff.valid && s1_ctl_ff.last) |=> (first_ff || s1_ctl_ff.first))
      else $error("fiber start lost after last point");

   // lower bound never exceeds upper bound while the range fits the output
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (COORD_WIDTH > OUT_WIDTH ||
                     (rsp_min_x <= rsp_max_x && rsp_min_y <= rsp_max_y &&
                      rsp_min_z <= rsp_max_z)))
      else $error("box lower bound above upper bound");

endmodule
